>>> src/dtmfs_pkg.sv
package dtmfs_pkg;

  // Depth of the key event queue and the widths that follow from it
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE  = 2'd0;
  localparam logic [1:0] CFG_FRAME_MS     = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RATE_RESET  = 16'd8000;
  localparam logic [6:0]  FRAME_RESET = 7'd20;
  localparam logic [6:0]  PTYPE_RESET = 7'd101;

  // Fixed payload volume and number of end-bit packets
  localparam logic [5:0] VOLUME_DEFAULT = 6'd20;
  localparam logic [1:0] END_REPEATS    = 2'd3;

  // Division by 1000 as multiply by reciprocal, exact for 30-bit dividends
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RK_NONE     = 2'd0,
    RK_PACKET   = 2'd1,
    RK_ACCEPTED = 2'd2,
    RK_DROPPED  = 2'd3
  } result_kind_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  key;
    logic [13:0] len;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    result_kind_e kind;
    logic [6:0]   pkt_type;
    logic         marker;
    logic [31:0]  pkt_ts;
    logic [7:0]   pkt_event;
    logic         end_flag;
    logic [5:0]   volume;
    logic [15:0]  duration;
    logic         busy;
  } result_t;

endpackage

>>> src/dtmf_event_packet_sender_core.sv
// Telephone-event packet sender. Push enqueue commands (key code, length in ms) and media
// ticks (RTP timestamp) into the input queue; exactly one result comes out of the result
// queue per command, in order. An enqueue, a tick that sends a progress or end packet, or a
// tick with nothing to send is retired in the decide step; a tick that starts a new event
// goes on to divide and launch: the event length and frame are converted to timestamp units
// by a sample-rate multiply followed by a reciprocal multiply for the divide by 1000, each
// registered. Two-entry queues on both sides let commands be pushed while results wait.
// Configuration is accepted in any cycle (ready is always high) and must only be written
// while no command is outstanding; conversion uses the values current when an event starts.
module dtmf_event_packet_sender_core import dtmfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [7:0]  key_code_i,
  input  logic [13:0] length_ms_i,
  input  logic [31:0] now_ts_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [6:0]  pkt_type_o,
  output logic        marker_o,
  output logic [31:0] pkt_ts_o,
  output logic [7:0]  pkt_event_o,
  output logic        end_flag_o,
  output logic [5:0]  volume_o,
  output logic [15:0] pkt_duration_o,
  output logic        busy_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  dtmfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .key_code_i  (key_code_i),
    .length_ms_i (length_ms_i),
    .now_ts_i    (now_ts_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  dtmfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  dtmfs_result_queue u_result_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty_o    (empty),
    .res_o      (res_out),
    .pop_i      (pop)
  );

  // Unpack the oldest result onto the ports
  assign result_kind_o  = res_out.kind;
  assign pkt_type_o     = res_out.pkt_type;
  assign marker_o       = res_out.marker;
  assign pkt_ts_o       = res_out.pkt_ts;
  assign pkt_event_o    = res_out.pkt_event;
  assign end_flag_o     = res_out.end_flag;
  assign volume_o       = res_out.volume;
  assign pkt_duration_o = res_out.duration;
  assign busy_res_o     = res_out.busy;

endmodule

>>> src/dtmfs_front.sv
module dtmfs_front import dtmfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        operation_i,
  input  logic [7:0]  key_code_i,
  input  logic [13:0] length_ms_i,
  input  logic [31:0] now_ts_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Classify the incoming item
  always_comb begin
    cmd_in.op  = operation_i ? OP_TICK : OP_ENQUEUE;
    cmd_in.key = key_code_i;
    cmd_in.len = length_ms_i;
    cmd_in.now = now_ts_i;
  end

  // Store the transfer in the command queue
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> src/dtmfs_back.sv
module dtmfs_back import dtmfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        res_push_o,
  output result_t     res_o,
  input  logic        res_full_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_DECIDE,
    ST_DIV,
    ST_LAUNCH
  } step_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SENDING,
    PH_ENDING
  } phase_e;

  // Configuration
  logic [15:0] rate_q;
  logic [6:0]  frame_q, ptype_q;

  // Event queue
  logic [21:0]       fifo_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head_q, head_d, tail;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [QCNT_W:0]   tail_sum;
  logic              fifo_we;
  logic [21:0]       head_entry;

  // Sender state
  step_e       step_q, step_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  key_q, key_d;
  logic [31:0] start_ts_q, start_ts_d;
  logic [31:0] base_ts_q, base_ts_d;
  logic [31:0] end_ts_q, end_ts_d;
  logic [15:0] total_q, total_d;
  logic [1:0]  repeats_q, repeats_d;

  // Conversion datapath
  logic [29:0] prod_dur_q;
  logic [22:0] prod_frm_q;
  logic [20:0] quo_dur_q;
  logic [13:0] quo_frm_q;
  logic [58:0] recip_dur;
  logic [51:0] recip_frm;
  logic        load_prod;
  logic [20:0] dur_ts;
  logic [31:0] diff_ts;

  assign head_entry = fifo_q[head_q];
  assign tail_sum   = (QCNT_W + 1)'(head_q) + (QCNT_W + 1)'(count_q);
  assign tail       = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
                    ? QIDX_W'(tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH))
                    : QIDX_W'(tail_sum);
  assign diff_ts    = cmd_i.now - end_ts_q;
  assign dur_ts     = (quo_dur_q < 21'(quo_frm_q)) ? 21'(quo_frm_q) : quo_dur_q;
  assign recip_dur  = 59'(prod_dur_q) * 59'(RECIP_1000);
  assign recip_frm  = 52'(prod_frm_q) * 52'(RECIP_1000);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RESET;
      frame_q <= FRAME_RESET;
      ptype_q <= PTYPE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_RATE:  rate_q  <= cfg_data_i;
        CFG_FRAME_MS:     frame_q <= cfg_data_i[6:0];
        CFG_PAYLOAD_TYPE: ptype_q <= cfg_data_i[6:0];
        default:          ;
      endcase
    end
  end

  // Sequence one command: decide, then for a new event divide and launch
  always_comb begin
    step_d     = step_q;
    phase_d    = phase_q;
    key_d      = key_q;
    start_ts_d = start_ts_q;
    base_ts_d  = base_ts_q;
    end_ts_d   = end_ts_q;
    total_d    = total_q;
    repeats_d  = repeats_q;
    head_d     = head_q;
    count_d    = count_q;
    fifo_we    = 1'b0;
    load_prod  = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.kind = RK_NONE;

    case (step_q)
      ST_DECIDE: begin
        if (cmd_valid_i && !res_full_i) begin
          if (cmd_i.op == OP_ENQUEUE) begin
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
            res_o.busy = (phase_q != PH_IDLE);
            if (count_q == QCNT_W'(QUEUE_DEPTH)) begin
              res_o.kind = RK_DROPPED;
            end else begin
              fifo_we    = 1'b1;
              count_d    = count_q + QCNT_W'(1);
              res_o.kind = RK_ACCEPTED;
            end
          end else if ((phase_q == PH_FIRST) || (phase_q == PH_SENDING)) begin
            cmd_pop_o      = 1'b1;
            res_push_o     = 1'b1;
            res_o.kind     = RK_PACKET;
            res_o.pkt_type = ptype_q;
            res_o.pkt_ts   = start_ts_q;
            res_o.pkt_event = key_q;
            res_o.volume   = VOLUME_DEFAULT;
            res_o.busy     = 1'b1;
            if (diff_ts[31]) begin
              // Progress packet, marked if first of the event
              res_o.marker   = (phase_q == PH_FIRST);
              res_o.duration = 16'(cmd_i.now - base_ts_q);
              phase_d        = PH_SENDING;
            end else begin
              // End reached: first end-bit packet
              res_o.end_flag = 1'b1;
              res_o.duration = total_q;
              phase_d        = PH_ENDING;
              repeats_d      = 2'd1;
            end
          end else if ((phase_q == PH_ENDING) && (repeats_q < END_REPEATS)) begin
            cmd_pop_o       = 1'b1;
            res_push_o      = 1'b1;
            res_o.kind      = RK_PACKET;
            res_o.pkt_type  = ptype_q;
            res_o.pkt_ts    = start_ts_q;
            res_o.pkt_event = key_q;
            res_o.end_flag  = 1'b1;
            res_o.volume    = VOLUME_DEFAULT;
            res_o.duration  = total_q;
            res_o.busy      = 1'b1;
            repeats_d       = repeats_q + 2'd1;
          end else if (count_q == '0) begin
            // Idle or finished, nothing queued
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
            res_o.busy = 1'b0;
            phase_d    = PH_IDLE;
          end else begin
            // Start the next queued event
            load_prod = 1'b1;
            key_d     = head_entry[21:14];
            head_d    = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
            count_d   = count_q - QCNT_W'(1);
            phase_d   = PH_FIRST;
            step_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        step_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (!res_full_i) begin
          cmd_pop_o       = 1'b1;
          res_push_o      = 1'b1;
          start_ts_d      = cmd_i.now;
          base_ts_d       = cmd_i.now - 32'(quo_frm_q);
          end_ts_d        = cmd_i.now + 32'(dur_ts);
          total_d         = dur_ts[15:0];
          res_o.kind      = RK_PACKET;
          res_o.pkt_type  = ptype_q;
          res_o.pkt_ts    = cmd_i.now;
          res_o.pkt_event = key_q;
          res_o.volume    = VOLUME_DEFAULT;
          res_o.busy      = 1'b1;
          if (dur_ts != '0) begin
            res_o.marker   = 1'b1;
            res_o.duration = 16'(quo_frm_q);
            phase_d        = PH_SENDING;
          end else begin
            // Zero length event goes straight to its end packets
            res_o.end_flag = 1'b1;
            res_o.duration = dur_ts[15:0];
            phase_d        = PH_ENDING;
            repeats_d      = 2'd1;
          end
          step_d = ST_DECIDE;
        end
      end
      default: begin
        step_d = ST_DECIDE;
      end
    endcase
  end

  // Hold event entries
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[tail] <= {cmd_i.key, cmd_i.len};
    end
  end

  // Multiply ms by rate, then by the reciprocal of 1000
  always_ff @(posedge clk_i) begin
    if (load_prod) begin
      prod_dur_q <= 30'(head_entry[13:0]) * 30'(rate_q);
      prod_frm_q <= 23'(frame_q) * 23'(rate_q);
    end
    if (step_q == ST_DIV) begin
      quo_dur_q <= recip_dur[58:RECIP_SHIFT];
      quo_frm_q <= recip_frm[51:RECIP_SHIFT];
    end
  end

  // Hold sender state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_DECIDE;
      phase_q    <= PH_IDLE;
      key_q      <= '0;
      start_ts_q <= '0;
      base_ts_q  <= '0;
      end_ts_q   <= '0;
      total_q    <= '0;
      repeats_q  <= '0;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      step_q     <= step_d;
      phase_q    <= phase_d;
      key_q      <= key_d;
      start_ts_q <= start_ts_d;
      base_ts_q  <= base_ts_d;
      end_ts_q   <= end_ts_d;
      total_q    <= total_d;
      repeats_q  <= repeats_d;
      head_q     <= head_d;
      count_q    <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("event queue fill level beyond depth");

  a_repeats_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    repeats_q <= END_REPEATS)
    else $error("end packet count beyond three");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_DECIDE) |-> (cmd_valid_i && (cmd_i.op == OP_TICK)))
    else $error("tick lost while its event is being launched");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (!res_full_i && cmd_pop_o))
    else $error("result pushed without space or without retiring its command");

  a_launch_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_DIV) |=> (step_q == ST_LAUNCH) && (phase_q == PH_FIRST))
    else $error("division step not followed by launch");

endmodule

>>> src/dtmfs_result_queue.sv
module dtmfs_result_queue import dtmfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_push_i,
  input  result_t res_i,
  output logic    res_full_o,
  output logic    empty_o,
  output result_t res_o,
  input  logic    pop_i
);

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign res_full_o = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign res_o      = slot_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  // Store finished results
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> test/dtmf_packet_checker.sv
module dtmf_packet_checker import dtmfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic              operation_i,
  input  logic [7:0]        key_code_i,
  input  logic [13:0]       length_ms_i,
  input  logic [31:0]       now_ts_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [1:0]        result_kind_i,
  input  logic [6:0]        pkt_type_i,
  input  logic              marker_i,
  input  logic [31:0]       pkt_ts_i,
  input  logic [7:0]        pkt_event_i,
  input  logic              end_flag_i,
  input  logic [5:0]        volume_i,
  input  logic [15:0]       pkt_duration_i,
  input  logic              busy_res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       fails_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       packets_o,
  output int unsigned       drops_o
);

  typedef enum logic [1:0] {
    SEND_IDLE,
    SEND_FIRST,
    SEND_PROGRESS,
    SEND_END
  } send_phase_e;

  // Register copies
  logic [15:0]  rate_hz;
  logic [6:0]   frame_len_ms;
  logic [6:0]   ptype;

  // Pending key events and the event being sent
  logic [21:0]  key_store [QUEUE_DEPTH];
  int unsigned  key_count;
  int unsigned  key_head;
  send_phase_e  phase;
  logic [7:0]   cur_key;
  logic [31:0]  ev_start;
  logic [31:0]  dur_base;
  logic [31:0]  ev_end;
  logic [31:0]  ev_total;
  int unsigned  end_sent;

  result_t      due_results [$];

  function automatic result_t make_packet(logic mark, logic end_bit, logic [31:0] span);
    result_t p;
    p           = '0;
    p.kind      = RK_PACKET;
    p.pkt_type  = ptype;
    p.marker    = mark;
    p.pkt_ts    = ev_start;
    p.pkt_event = cur_key;
    p.end_flag  = end_bit;
    p.volume    = VOLUME_DEFAULT;
    p.duration  = span[15:0];
    return p;
  endfunction

  // Advance the sender by one command and return the result it gives
  function automatic result_t step_sender(cmd_t c);
    result_t     r;
    logic [31:0] frame_ts;
    logic [31:0] span_ts;
    logic [31:0] lag;
    logic [21:0] entry;
    bit          settled;
    r      = '0;
    r.kind = RK_NONE;
    settled = 1'b0;
    if (c.op == OP_ENQUEUE) begin
      if (key_count >= QUEUE_DEPTH) begin
        r.kind = RK_DROPPED;
      end else begin
        key_store[(key_head + key_count) % QUEUE_DEPTH] = {c.key, c.len};
        key_count++;
        r.kind = RK_ACCEPTED;
      end
      settled = 1'b1;
    end
    while (!settled) begin
      case (phase)
        SEND_IDLE: begin
          if (key_count == 0) begin
            settled = 1'b1;
          end else begin
            // start the oldest queued event, converting with current registers
            entry    = key_store[key_head];
            key_head = (key_head + 1) % QUEUE_DEPTH;
            key_count--;
            cur_key  = entry[21:14];
            frame_ts = (32'(frame_len_ms) * 32'(rate_hz)) / 1000;
            span_ts  = (32'(entry[13:0]) * 32'(rate_hz)) / 1000;
            if (span_ts < frame_ts) span_ts = frame_ts;
            ev_total = span_ts;
            ev_start = c.now;
            dur_base = c.now - frame_ts;
            ev_end   = c.now + span_ts;
            phase    = SEND_FIRST;
          end
        end
        SEND_FIRST, SEND_PROGRESS: begin
          // serial-number compare: still before the end timestamp?
          lag = c.now - ev_end;
          if (lag[31]) begin
            r       = make_packet(phase == SEND_FIRST, 1'b0, c.now - dur_base);
            phase   = SEND_PROGRESS;
            settled = 1'b1;
          end else begin
            phase    = SEND_END;
            end_sent = 0;
          end
        end
        default: begin
          if (end_sent >= END_REPEATS) begin
            phase = SEND_IDLE;
          end else begin
            end_sent++;
            r       = make_packet(1'b0, 1'b1, ev_total);
            settled = 1'b1;
          end
        end
      endcase
    end
    r.busy = (phase != SEND_IDLE);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cmd_t    c;
    result_t want;
    if (!rst_ni) begin
      rate_hz      = RATE_RESET;
      frame_len_ms = FRAME_RESET;
      ptype        = PTYPE_RESET;
      key_count    = 0;
      key_head     = 0;
      phase        = SEND_IDLE;
      cur_key      = '0;
      ev_start     = '0;
      dur_base     = '0;
      ev_end       = '0;
      ev_total     = '0;
      end_sent     = 0;
      due_results.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_RATE:  rate_hz      = cfg_data_i;
          CFG_FRAME_MS:     frame_len_ms = cfg_data_i[6:0];
          CFG_PAYLOAD_TYPE: ptype        = cfg_data_i[6:0];
          default: ;
        endcase
      end
      // compare each result transfer with the oldest expectation
      if (pop_i && !empty_i) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: result_kind 0x%0h", result_kind_i);
          fails_o++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.kind, result_kind_i);
          check_field("pkt_type", want.pkt_type, pkt_type_i);
          check_field("marker", want.marker, marker_i);
          check_field("pkt_ts", want.pkt_ts, pkt_ts_i);
          check_field("pkt_event", want.pkt_event, pkt_event_i);
          check_field("end_flag", want.end_flag, end_flag_i);
          check_field("volume", want.volume, volume_i);
          check_field("pkt_duration", want.duration, pkt_duration_i);
          check_field("busy_res", want.busy, busy_res_i);
          checked_o++;
          if (want.kind == RK_PACKET) packets_o++;
          if (want.kind == RK_DROPPED) drops_o++;
        end
      end
      // predict each command transfer
      if (push_i && !full_i) begin
        c.op  = op_e'(operation_i);
        c.key = key_code_i;
        c.len = length_ms_i;
        c.now = now_ts_i;
        due_results.push_back(step_sender(c));
      end
    end
    pending_o <= due_results.size();
  end

  initial begin
    fails_o   = 0;
    pending_o = 0;
    checked_o = 0;
    packets_o = 0;
    drops_o   = 0;
  end

endmodule

>>> test/testbench.sv
module testbench;
  import dtmfs_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic        operation_i = 1'b0;
  logic [7:0]  key_code_i  = '0;
  logic [13:0] length_ms_i = '0;
  logic [31:0] now_ts_i    = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [1:0]  result_kind_o;
  logic [6:0]  pkt_type_o;
  logic        marker_o;
  logic [31:0] pkt_ts_o;
  logic [7:0]  pkt_event_o;
  logic        end_flag_o;
  logic [5:0]  volume_o;
  logic [15:0] pkt_duration_o;
  logic        busy_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;
  int unsigned packets;
  int unsigned drops;

  // Stimulus shaping state
  logic        quiet      = 1'b0;
  logic [31:0] ts_clock   = '0;
  logic [31:0] frame_step = 32'd160;
  int unsigned commands_sent = 0;

  always #4 clk_i = ~clk_i;

  dtmf_event_packet_sender_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .key_code_i     (key_code_i),
    .length_ms_i    (length_ms_i),
    .now_ts_i       (now_ts_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .pkt_type_o     (pkt_type_o),
    .marker_o       (marker_o),
    .pkt_ts_o       (pkt_ts_o),
    .pkt_event_o    (pkt_event_o),
    .end_flag_o     (end_flag_o),
    .volume_o       (volume_o),
    .pkt_duration_o (pkt_duration_o),
    .busy_res_o     (busy_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  dtmf_packet_checker packet_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .operation_i    (operation_i),
    .key_code_i     (key_code_i),
    .length_ms_i    (length_ms_i),
    .now_ts_i       (now_ts_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_kind_i  (result_kind_o),
    .pkt_type_i     (pkt_type_o),
    .marker_i       (marker_o),
    .pkt_ts_i       (pkt_ts_o),
    .pkt_event_i    (pkt_event_o),
    .end_flag_i     (end_flag_o),
    .volume_i       (volume_o),
    .pkt_duration_i (pkt_duration_o),
    .busy_res_i     (busy_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fails_o        (fails),
    .pending_o      (pending),
    .checked_o      (checked),
    .packets_o      (packets),
    .drops_o        (drops)
  );

  // Offer one command and hold it until the transfer
  task automatic send_cmd(op_e op, logic [7:0] key, logic [13:0] len, logic [31:0] now);
    operation_i <= op;
    key_code_i  <= key;
    length_ms_i <= len;
    now_ts_i    <= now;
    push        <= 1'b1;
    do @(posedge clk_i); while (full);
    commands_sent++;
  endtask

  task automatic send_key(logic [7:0] key, logic [13:0] len);
    send_cmd(OP_ENQUEUE, key, len, $urandom);
  endtask

  task automatic send_tick(logic [31:0] now);
    send_cmd(OP_TICK, 8'($urandom), 14'($urandom), now);
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] rate_word, logic [15:0] frame_word,
                            logic [15:0] ptype_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SAMPLE_RATE;
    cfg_data_i  <= rate_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_FRAME_MS;
    cfg_data_i  <= frame_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_PAYLOAD_TYPE;
    cfg_data_i  <= ptype_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frame_step = (32'(frame_word[6:0]) * 32'(rate_word)) / 1000;
  endtask

  // Mostly frame-paced ticks with occasional enqueues, jumps and stray timestamps
  task automatic random_traffic(int unsigned count);
    int unsigned pick;
    int unsigned span;
    ts_clock = $urandom;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        span = $urandom_range(0, 99);
        if (span < 80)      send_key(8'($urandom), 14'($urandom_range(0, 300)));
        else if (span < 95) send_key(8'($urandom), 14'($urandom_range(0, 2000)));
        else                send_key(8'($urandom), 14'($urandom_range(0, 16383)));
      end else begin
        if (pick < 23)      ts_clock = $urandom;
        else if (pick < 28) ts_clock += $urandom_range(0, 40000);
        else if (pick < 31) ts_clock -= $urandom_range(1, 500);
        else if (frame_step != 0) ts_clock += frame_step;
        else                ts_clock += $urandom_range(1, 50);
        send_tick(ts_clock);
      end
      // random sender gaps
      if (!quiet && $urandom_range(0, 4) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  // Result side: random stalls, plus long hold-offs to back up the input
  initial begin : result_drain
    int unsigned drained;
    int unsigned next_hold;
    drained   = 0;
    next_hold = 250;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) drained++;
      if (drained >= next_hold) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        next_hold += 400;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, fill the queue, overflow, then wrap and jump cases
    send_tick(32'h0000_0000);
    send_key(8'h00, 14'd0);
    send_key(8'hFF, 14'h3FFF);
    for (int k = 1; k <= 6; k++) send_key(8'(k * 37), 14'(k * 5));
    send_key(8'hA5, 14'h2AAA);
    send_tick(32'hFFFF_FFF0);
    send_tick(32'h0000_0090);
    send_tick(32'h0000_0130);
    send_tick(32'h0000_01D0);
    send_tick(32'h0000_1000);
    send_tick(32'h0000_0FFB);
    send_tick(32'h8000_1000);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain_results();
        repeat (8) @(posedge clk_i);
        case (ph)
          1: write_regs(16'd48000, 16'h0064, 16'h007F);
          2: write_regs(16'hFFFF, 16'hFF80, 16'h0000);
          3: write_regs(16'h0000, 16'hFFFF, 16'hFFFF);
          4: write_regs(16'($urandom_range(8000, 48000)), 16'($urandom_range(1, 100)),
                        16'($urandom_range(0, 127)));
          default: begin
            write_regs(16'd16000, 16'h0001, 16'h0060);
            quiet <= 1'b1;
          end
        endcase
      end
      random_traffic(165);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d commands under six register settings, %0d results checked.",
             commands_sent, checked);
    $display("%0d packets compared and %0d enqueues dropped on a full queue.",
             packets, drops);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #(8 * 400000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
